// File: src/bcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types, constants and helpers for the BCD clock/calendar counter.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int PRESCALER_BITS_DEF = 24;
  localparam int TPS_W              = 24;
  localparam int ELAPSED_W          = 8;
  localparam int CFG_IDX_W          = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_ENABLE     = 1'd1;

  localparam logic [TPS_W-1:0] TPS_RESET = 24'd6144000;
  localparam logic             CLK_EN_RESET = 1'b1;

  // calendar limits
  localparam logic [7:0] BCD_LIMIT_SEXA  = 8'h59;
  localparam logic [7:0] BCD_LIMIT_HOUR  = 8'h23;
  localparam logic [7:0] BCD_LIMIT_MONTH = 8'h12;
  localparam logic [7:0] BCD_LIMIT_YEAR  = 8'h99;
  localparam logic [7:0] BCD_DAYS_31     = 8'h31;
  localparam logic [7:0] BCD_DAYS_30     = 8'h30;
  localparam logic [7:0] BCD_DAYS_29     = 8'h29;
  localparam logic [7:0] BCD_DAYS_28     = 8'h28;
  localparam logic [7:0] BCD_ONE         = 8'h01;
  localparam logic [2:0] WEEKDAY_LIMIT   = 3'd7;

  typedef struct packed {
    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hour;
    logic [2:0] weekday;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year;
  } calendar_t;

  localparam calendar_t CAL_RESET = '{
    sec: 8'h00, min: 8'h00, hour: 8'h00, weekday: 3'd0,
    day: 8'h01, month: 8'h01, year: 8'h00
  };

  // add one with decimal adjust of the low digit, 8-bit wrapping
  function automatic logic [7:0] bcd_inc(input logic [7:0] v);
    logic [7:0] t;
    t = v + 8'd1;
    if (t[3:0] >= 4'ha) begin
      t = t + 8'd6;
    end
    return t;
  endfunction

endpackage

// File: src/bcd_clock_calendar_counter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_clock_calendar_counter_top
// Prescaled BCD real-time clock and calendar with request/result channels.
// ----------------------------------------------------------------------------
// Each request carries a count of elapsed clock cycles; the block adds it to a
// prescaler and, once ticks_per_second is reached, advances the BCD calendar
// by one second (when clock_enable is set). Every request yields exactly one
// result holding the tick flag and the full time and date after that request.
// A request is captured in an input register, processed by the prescaler and
// the calendar carry chain as it moves on, and lands in an output register:
// one request per cycle while the output register is free or draining.
// Only a stalled output slows intake.
// ----------------------------------------------------------------------------
module bcd_clock_calendar_counter_top #(
  parameter int PRESCALER_BITS = bcc_pkg::PRESCALER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bcc_pkg::ELAPSED_W-1:0]  in_elapsed_clocks,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_second_tick,
  output logic [7:0]                     out_seconds_bcd,
  output logic [7:0]                     out_minutes_bcd,
  output logic [7:0]                     out_hours_bcd,
  output logic [2:0]                     out_weekday_now,
  output logic [7:0]                     out_day_bcd,
  output logic [7:0]                     out_month_bcd,
  output logic [7:0]                     out_year_bcd,
  input  logic                           cfg_we,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bcc_pkg::TPS_W-1:0]      cfg_wdata
);

  logic [bcc_pkg::TPS_W-1:0]     tps_r;
  logic                          clk_en_r;
  logic                          req_valid_r;
  logic [bcc_pkg::ELAPSED_W-1:0] req_elapsed_r;
  logic                          out_valid_r;
  logic                          out_tick_r;
  bcc_pkg::calendar_t            out_cal_r;
  logic                          advance;
  logic                          tick;
  bcc_pkg::calendar_t            cal_after;

  // the held request moves on when the output register is free or draining
  assign advance  = req_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !req_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r    <= bcc_pkg::TPS_RESET;
      clk_en_r <= bcc_pkg::CLK_EN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bcc_pkg::CFG_TICKS_PER_SECOND: begin
          tps_r <= cfg_wdata;
        end
        bcc_pkg::CFG_CLOCK_ENABLE: begin
          clk_en_r <= cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  bcc_prescaler #(
    .PRESCALER_BITS (PRESCALER_BITS)
  ) u_prescaler (
    .clk              (clk),
    .rst_n            (rst_n),
    .advance          (advance),
    .elapsed          (req_elapsed_r),
    .ticks_per_second (tps_r),
    .tick             (tick)
  );

  bcc_calendar u_calendar (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .add_second (tick && clk_en_r),
    .cal_after  (cal_after)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        req_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_elapsed_r <= in_elapsed_clocks;
    end
    if (advance) begin
      out_tick_r <= tick;
      out_cal_r  <= cal_after;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_second_tick = out_tick_r;
  assign out_seconds_bcd = out_cal_r.sec;
  assign out_minutes_bcd = out_cal_r.min;
  assign out_hours_bcd   = out_cal_r.hour;
  assign out_weekday_now = out_cal_r.weekday;
  assign out_day_bcd     = out_cal_r.day;
  assign out_month_bcd   = out_cal_r.month;
  assign out_year_bcd    = out_cal_r.year;

endmodule

// File: src/bcc_prescaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_prescaler
// Accumulates elapsed clock cycles and flags each completed second.
// ----------------------------------------------------------------------------
module bcc_prescaler #(
  parameter int PRESCALER_BITS = bcc_pkg::PRESCALER_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic [bcc_pkg::ELAPSED_W-1:0] elapsed,
  input  logic [bcc_pkg::TPS_W-1:0]    ticks_per_second,
  output logic                         tick
);

  localparam int SUM_W = PRESCALER_BITS + 1;
  localparam int CMP_W = (SUM_W > bcc_pkg::TPS_W) ? SUM_W : bcc_pkg::TPS_W;

  logic [PRESCALER_BITS-1:0] prescaler_r;
  logic [PRESCALER_BITS-1:0] prescaler_nxt;
  logic [CMP_W-1:0]          sum;
  logic [CMP_W-1:0]          tps_ext;
  logic [CMP_W-1:0]          diff;

  always_comb begin
    sum     = CMP_W'(prescaler_r) + CMP_W'(elapsed);
    tps_ext = CMP_W'(ticks_per_second);
    diff    = sum - tps_ext;
    tick    = (sum >= tps_ext);
    // compare and subtract on the full sum, then wrap
    prescaler_nxt = tick ? diff[PRESCALER_BITS-1:0] : sum[PRESCALER_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescaler_r <= '0;
    end else if (advance) begin
      prescaler_r <= prescaler_nxt;
    end
  end

endmodule

// File: src/bcc_calendar.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_calendar
// BCD time and date registers with a one-second carry chain.
// ----------------------------------------------------------------------------
module bcc_calendar (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  logic               add_second,
  output bcc_pkg::calendar_t cal_after
);

  bcc_pkg::calendar_t cal_r;
  bcc_pkg::calendar_t cal_nxt;

  logic [8:0] sec_step;
  logic [8:0] min_step;
  logic [7:0] hour_inc;
  logic [2:0] wd_inc;
  logic [7:0] day_inc;
  logic [7:0] month_inc;
  logic [7:0] year_inc;
  logic [7:0] month_len;
  logic [1:0] leap_mod;

  // seconds/minutes: compare only when the low digit rolled past nine
  // bit 8 flags the wrap to zero that carries into the next stage
  function automatic logic [8:0] sexa_step(input logic [7:0] v);
    logic [7:0] t;
    logic [7:0] u;
    t = v + 8'd1;
    u = t + 8'd6;
    if (t[3:0] <= 4'd9) begin
      return {1'b0, t};
    end else if (u <= bcc_pkg::BCD_LIMIT_SEXA) begin
      return {1'b0, u};
    end else begin
      return {1'b1, 8'h00};
    end
  endfunction

  always_comb begin
    // year as tens*10+units, mod 4 == (2*tens + units) mod 4
    leap_mod = {cal_r.year[4], 1'b0} + cal_r.year[1:0];
    case (cal_r.month)
      8'h02: begin
        month_len = (leap_mod == 2'd0) ? bcc_pkg::BCD_DAYS_29 : bcc_pkg::BCD_DAYS_28;
      end
      8'h04, 8'h06, 8'h09, 8'h11: begin
        month_len = bcc_pkg::BCD_DAYS_30;
      end
      default: begin
        month_len = bcc_pkg::BCD_DAYS_31;
      end
    endcase
  end

  always_comb begin
    sec_step  = sexa_step(cal_r.sec);
    min_step  = sexa_step(cal_r.min);
    hour_inc  = bcc_pkg::bcd_inc(cal_r.hour);
    wd_inc    = cal_r.weekday + 3'd1;
    day_inc   = bcc_pkg::bcd_inc(cal_r.day);
    month_inc = bcc_pkg::bcd_inc(cal_r.month);
    year_inc  = bcc_pkg::bcd_inc(cal_r.year);

    cal_nxt     = cal_r;
    cal_nxt.sec = sec_step[7:0];
    if (sec_step[8]) begin
      // seconds wrapped, carry into minutes
      cal_nxt.min = min_step[7:0];
      if (min_step[8]) begin
        if (hour_inc <= bcc_pkg::BCD_LIMIT_HOUR) begin
          cal_nxt.hour = hour_inc;
        end else begin
          cal_nxt.hour    = 8'h00;
          cal_nxt.weekday = (wd_inc >= bcc_pkg::WEEKDAY_LIMIT) ? 3'd0 : wd_inc;
          if (day_inc <= month_len) begin
            cal_nxt.day = day_inc;
          end else begin
            cal_nxt.day = bcc_pkg::BCD_ONE;
            if (month_inc <= bcc_pkg::BCD_LIMIT_MONTH) begin
              cal_nxt.month = month_inc;
            end else begin
              cal_nxt.month = bcc_pkg::BCD_ONE;
              cal_nxt.year  = (year_inc <= bcc_pkg::BCD_LIMIT_YEAR) ? year_inc : 8'h00;
            end
          end
        end
      end
    end
  end

  assign cal_after = add_second ? cal_nxt : cal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= bcc_pkg::CAL_RESET;
    end else if (advance) begin
      cal_r <= cal_after;
    end
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the BCD clock/calendar counter.
// ----------------------------------------------------------------------------
// Requests of elapsed clock counts go in through the valid/ready channel with
// random gaps. A local model of the prescaler and the BCD carry chain predicts
// the tick flag and the full date/time for every accepted request. Each
// result is compared field by field against the oldest prediction. The bench
// runs directed cases, clock freeze, periods below the legal range,
// back-pressure, a run of one second per request across a minute carry and
// a long random section with changing periods.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          PSC_W       = bcc_pkg::PRESCALER_BITS_DEF;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam logic [23:0] TPS_MAX     = 24'hffffff;
  localparam logic [23:0] TPS_MIN     = 24'd256;

  typedef struct packed {
    logic               tick;
    bcc_pkg::calendar_t cal;
  } rtc_result_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [bcc_pkg::ELAPSED_W-1:0] in_elapsed_clocks;
  logic                          out_valid;
  logic                          out_ready;
  logic                          out_second_tick;
  logic [7:0]                    out_seconds_bcd;
  logic [7:0]                    out_minutes_bcd;
  logic [7:0]                    out_hours_bcd;
  logic [2:0]                    out_weekday_now;
  logic [7:0]                    out_day_bcd;
  logic [7:0]                    out_month_bcd;
  logic [7:0]                    out_year_bcd;
  logic                          cfg_we;
  logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bcc_pkg::TPS_W-1:0]     cfg_wdata;

  // local model state
  logic [PSC_W-1:0]          rtc_prescaler;
  logic [bcc_pkg::TPS_W-1:0] rtc_tps;
  logic                      rtc_enable;
  bcc_pkg::calendar_t        rtc_cal;
  rtc_result_t               rtc_expected_q[$];

  bit tx_idle_on;
  bit rx_idle_on;
  int rx_hold_cycles;
  int mismatches;
  int n_requests;
  int n_results;
  int n_ticks;
  int cycle_count;

  bcd_clock_calendar_counter_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_elapsed_clocks (in_elapsed_clocks),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_second_tick   (out_second_tick),
    .out_seconds_bcd   (out_seconds_bcd),
    .out_minutes_bcd   (out_minutes_bcd),
    .out_hours_bcd     (out_hours_bcd),
    .out_weekday_now   (out_weekday_now),
    .out_day_bcd       (out_day_bcd),
    .out_month_bcd     (out_month_bcd),
    .out_year_bcd      (out_year_bcd),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               rtc_expected_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // calendar model
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] bcd_step(input logic [7:0] v);
    logic [7:0] t;
    t = v + 8'd1;
    if (t[3:0] >= 4'ha) begin
      t = t + 8'd6;
    end
    return t;
  endfunction

  function automatic logic [7:0] days_in_month(input logic [7:0] month,
                                               input logic [7:0] year);
    int year_val;
    year_val = int'(year[7:4]) * 10 + int'(year[3:0]);
    case (month)
      8'h02: begin
        return (year_val % 4 == 0) ? bcc_pkg::BCD_DAYS_29 : bcc_pkg::BCD_DAYS_28;
      end
      8'h04, 8'h06, 8'h09, 8'h11: return bcc_pkg::BCD_DAYS_30;
      default:                    return bcc_pkg::BCD_DAYS_31;
    endcase
  endfunction

  // seconds and minutes only adjust once the low digit overflows
  function automatic bcc_pkg::calendar_t next_second(input bcc_pkg::calendar_t c);
    c.sec = c.sec + 8'd1;
    if (c.sec[3:0] <= 4'd9) return c;
    c.sec = c.sec + 8'd6;
    if (c.sec <= bcc_pkg::BCD_LIMIT_SEXA) return c;
    c.sec = 8'h00;

    c.min = c.min + 8'd1;
    if (c.min[3:0] <= 4'd9) return c;
    c.min = c.min + 8'd6;
    if (c.min <= bcc_pkg::BCD_LIMIT_SEXA) return c;
    c.min = 8'h00;

    c.hour = bcd_step(c.hour);
    if (c.hour <= bcc_pkg::BCD_LIMIT_HOUR) return c;
    c.hour = 8'h00;

    c.weekday = c.weekday + 3'd1;
    if (c.weekday >= bcc_pkg::WEEKDAY_LIMIT) c.weekday = 3'd0;

    c.day = bcd_step(c.day);
    if (c.day <= days_in_month(c.month, c.year)) return c;
    c.day = bcc_pkg::BCD_ONE;

    c.month = bcd_step(c.month);
    if (c.month <= bcc_pkg::BCD_LIMIT_MONTH) return c;
    c.month = bcc_pkg::BCD_ONE;

    c.year = bcd_step(c.year);
    if (c.year <= bcc_pkg::BCD_LIMIT_YEAR) return c;
    c.year = 8'h00;
    return c;
  endfunction

  // compare and subtract on the full sum, store wraps to the prescaler width
  function automatic rtc_result_t predict_rtc_result(input logic [7:0] elapsed);
    logic [32:0] sum;
    rtc_result_t r;
    sum = 33'(rtc_prescaler);
    sum = sum + 33'(elapsed);
    r.tick = 1'b0;
    if (sum >= 33'(rtc_tps)) begin
      sum = sum - 33'(rtc_tps);
      r.tick = 1'b1;
    end
    rtc_prescaler = sum[PSC_W-1:0];
    if (r.tick && rtc_enable) rtc_cal = next_second(rtc_cal);
    r.cal = rtc_cal;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [7:0] elapsed);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    in_elapsed_clocks <= elapsed;
    do @(posedge clk); while (in_ready !== 1'b1);
    rtc_expected_q.push_back(predict_rtc_result(elapsed));
    n_requests++;
  endtask

  task automatic send_random_request;
    logic [7:0] elapsed;
    elapsed = 8'($urandom());
    if ($urandom_range(0, 3) == 0) elapsed = 8'hff;
    send_request(elapsed);
  endtask

  task automatic wait_results_drained;
    @(negedge clk);
    in_valid <= 1'b0;
    while (rtc_expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bcc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bcc_pkg::TPS_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == bcc_pkg::CFG_TICKS_PER_SECOND) rtc_tps = data;
    else rtc_enable = data[0];
  endtask

  // receiver: random stall per result, or one long hold when asked
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, 9) : 0;
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // checker
  // ---------------------------------------------------------------------------
  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %h got %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    rtc_result_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (rtc_expected_q.size() == 0) begin
        $display("%0t ns: result with no request pending, expected none got %h:%h:%h",
                 $time, out_hours_bcd, out_minutes_bcd, out_seconds_bcd);
        mismatches++;
      end else begin
        want = rtc_expected_q.pop_front();
        check_field("second_tick", 8'(want.tick),        8'(out_second_tick));
        check_field("seconds",     want.cal.sec,         out_seconds_bcd);
        check_field("minutes",     want.cal.min,         out_minutes_bcd);
        check_field("hours",       want.cal.hour,        out_hours_bcd);
        check_field("weekday",     8'(want.cal.weekday), 8'(out_weekday_now));
        check_field("day",         want.cal.day,         out_day_bcd);
        check_field("month",       want.cal.month,       out_month_bcd);
        check_field("year",        want.cal.year,        out_year_bcd);
        n_results++;
        if (want.tick) n_ticks++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_field_extremes;
    wait_results_drained();
    write_reg(bcc_pkg::CFG_TICKS_PER_SECOND, TPS_MIN);
    tx_idle_on = 1;
    rx_idle_on = 1;
    // two full counts complete only one second
    send_request(8'h00);
    send_request(8'hff);
    send_request(8'hff);
    send_request(8'h01);
    send_request(8'h01);
    send_request(8'h80);
  endtask

  task automatic test_clock_freeze;
    wait_results_drained();
    write_reg(bcc_pkg::CFG_CLOCK_ENABLE, 24'd0);
    repeat (3) send_request(8'hff);
    wait_results_drained();
    write_reg(bcc_pkg::CFG_CLOCK_ENABLE, 24'd1);
  endtask

  task automatic test_short_period;
    wait_results_drained();
    write_reg(bcc_pkg::CFG_TICKS_PER_SECOND, 24'd4000);
    repeat (8) send_request(8'hff);
    // period below the legal range: the stored count drains a second per request
    wait_results_drained();
    write_reg(bcc_pkg::CFG_TICKS_PER_SECOND, 24'd200);
    repeat (6) send_request(8'h00);
    // zero period ticks on every request
    wait_results_drained();
    write_reg(bcc_pkg::CFG_TICKS_PER_SECOND, 24'd0);
    repeat (3) send_random_request();
  endtask

  task automatic test_backpressure;
    wait_results_drained();
    write_reg(bcc_pkg::CFG_TICKS_PER_SECOND, 24'd300);
    tx_idle_on = 0;
    rx_hold_cycles = 60;
    repeat (30) send_random_request();
    wait_results_drained();
    tx_idle_on = 1;
  endtask

  // one second per request, long enough to carry into the minutes
  task automatic test_minute_carry;
    wait_results_drained();
    write_reg(bcc_pkg::CFG_TICKS_PER_SECOND, 24'd0);
    write_reg(bcc_pkg::CFG_CLOCK_ENABLE, 24'd1);
    tx_idle_on = 0;
    rx_idle_on = 0;
    repeat (70) send_random_request();
    wait_results_drained();
    tx_idle_on = 1;
    rx_idle_on = 1;
  endtask

  task automatic test_random_traffic;
    int n_sent;
    int chunk;
    int blocks;
    logic [23:0] tps;
    logic en;
    n_sent = 0;
    blocks = 0;
    while (n_sent < 380) begin
      wait_results_drained();
      case ($urandom_range(0, 9))
        0:       tps = TPS_MAX;
        1:       tps = TPS_MIN;
        2:       tps = 24'($urandom_range(0, 255));
        3:       tps = 24'($urandom());
        default: tps = 24'($urandom_range(256, 1500));
      endcase
      en = ($urandom_range(0, 5) != 0);
      write_reg(bcc_pkg::CFG_TICKS_PER_SECOND, tps);
      write_reg(bcc_pkg::CFG_CLOCK_ENABLE, {23'd0, en});
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if (blocks % 4 == 3) begin
        tx_idle_on = 0;
        rx_hold_cycles = $urandom_range(30, 80);
      end
      chunk = $urandom_range(15, 50);
      repeat (chunk) send_random_request();
      n_sent += chunk;
      blocks++;
    end
    wait_results_drained();
  endtask

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_elapsed_clocks = '0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    tx_idle_on        = 1;
    rx_idle_on        = 1;
    rx_hold_cycles    = 0;
    mismatches        = 0;
    n_requests        = 0;
    n_results         = 0;
    n_ticks           = 0;
    cycle_count       = 0;
    rtc_prescaler     = '0;
    rtc_tps           = bcc_pkg::TPS_RESET;
    rtc_enable        = bcc_pkg::CLK_EN_RESET;
    rtc_cal           = bcc_pkg::CAL_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    test_clock_freeze();
    test_short_period();
    test_backpressure();
    test_minute_carry();
    test_random_traffic();

    wait_results_drained();
    repeat (10) @(posedge clk);
    $display("run covered %0d requests and %0d results, %0d of them completing a second",
             n_requests, n_results, n_ticks);
    $display("calendar ended at day %h month %h weekday %0d, time %h:%h:%h",
             rtc_cal.day, rtc_cal.month, rtc_cal.weekday, rtc_cal.hour, rtc_cal.min,
             rtc_cal.sec);
    if (mismatches == 0 && rtc_expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
